// ===== design/lru_block_cache_directory_defines.svh =====
// Assertion helpers shared by the directory RTL.
`ifndef LRU_BLOCK_CACHE_DIRECTORY_DEFINES_SVH
`define LRU_BLOCK_CACHE_DIRECTORY_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define LBCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset.
`define LBCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lbcd_pkg.sv =====
`timescale 1ns / 1ps
package lbcd_pkg;

    localparam int TAG_W           = 32;
    localparam int OUT_SLOT_W      = 6;
    localparam int ACT_W           = 2;
    localparam int DEFAULT_ENTRIES = 64;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE       = 2'd0,
        ACT_FETCH      = 2'd1,
        ACT_WRITE      = 2'd2,
        ACT_WRITE_DIFF = 2'd3
    } action_t;

    typedef struct packed {
        logic             command;
        logic [TAG_W-1:0] block_number;
    } req_t;

    typedef struct packed {
        logic                  hit;
        logic [OUT_SLOT_W-1:0] slot;
        logic                  evicted;
        logic [TAG_W-1:0]      evicted_block;
        logic [ACT_W-1:0]      backing_action;
    } rsp_t;

    // Controls broadcast to every cell of the recency chain.
    typedef struct packed {
        logic capture;
        logic shift;
    } cell_ctl_t;

endpackage

// ===== design/lbcd_if.sv =====
`timescale 1ns / 1ps
interface lbcd_req_if import lbcd_pkg::*;;
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lbcd_rsp_if import lbcd_pkg::*;;
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/lbcd_cell.sv =====
`timescale 1ns / 1ps
// One recency position: holds a tag and its slot, compares against the
// search key, and takes its predecessor's entry when the chain shifts.
module lbcd_cell import lbcd_pkg::*; #(
    parameter int SLOT_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctl_t         ctl,
    input  logic [TAG_W-1:0]  key,
    input  logic              prev_valid,
    input  logic [TAG_W-1:0]  prev_tag,
    input  logic [SLOT_W-1:0] prev_slot,
    input  logic              shift_in,
    output logic              shift_out,
    output logic              valid,
    output logic [TAG_W-1:0]  tag,
    output logic [SLOT_W-1:0] slot,
    output logic              match
);

    logic              valid_reg;
    logic              valid_next;
    logic [TAG_W-1:0]  tag_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              match_reg;
    logic              match_next;
    logic              take;

    // This cell moves when it or any later cell holds the hit (or on a miss).
    assign shift_out = match_reg | shift_in;
    assign take      = ctl.shift & shift_out;

    assign match_next = ctl.capture ? (valid_reg & (tag_reg == key)) : match_reg;
    assign valid_next = take ? prev_valid : valid_reg;

    // Hold occupancy and match flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    // Advance the entry from the neighbor.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tag_reg  <= prev_tag;
            slot_reg <= prev_slot;
        end
    end

    assign valid = valid_reg;
    assign tag   = tag_reg;
    assign slot  = slot_reg;
    assign match = match_reg;

endmodule

// ===== design/lru_block_cache_directory.sv =====
`timescale 1ns / 1ps
// Flow: an accepted request goes through the MATCH state (cells register their
// tag compare) and the APPLY state (chain shift, result registered), which
// stalls on an untaken result; requests are taken in IDLE or as APPLY fires.
// Reset: asynchronous, active low; empties the directory (all cells invalid,
// count zero) with no clearing pass.
`include "lru_block_cache_directory_defines.svh"

module lru_block_cache_directory import lbcd_pkg::*; #(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  logic       clk,
    input  logic       rst_n,
    lbcd_req_if.sink   req,
    lbcd_rsp_if.source rsp
);

    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MATCH = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [TAG_W-1:0] key_reg;
    logic             cmd_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    rsp_t             out_reg;
    rsp_t             out_next;

    logic              valid_vec [ENTRIES];
    logic [TAG_W-1:0]  tag_arr   [ENTRIES];
    logic [SLOT_W-1:0] slot_arr  [ENTRIES];
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES:0]  chain;

    cell_ctl_t         ctl;
    logic              accept;
    logic              fire;
    logic              hit;
    logic              full;
    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] new_slot;
    logic [SLOT_W+OUT_SLOT_W-1:0] slot_wide;

    // Handshake and stage control.
    assign fire   = (state_reg == ST_APPLY) && (!out_valid_reg || rsp.ready);
    assign req.ready = (state_reg == ST_IDLE) || fire;
    assign accept = req.valid && req.ready;

    assign ctl.capture = (state_reg == ST_MATCH);
    assign ctl.shift   = fire;

    // Hit detection and slot selection.
    assign hit  = |match_vec;
    assign full = (count_reg == CNT_W'(ENTRIES));

    always_comb
    begin
        hit_slot = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_slot = hit_slot | (match_vec[i] ? slot_arr[i] : '0);
        end
    end

    assign new_slot = hit ? hit_slot
                    : (full ? slot_arr[ENTRIES-1] : count_reg[SLOT_W-1:0]);

    // A miss shifts the whole chain; a hit shifts from its position forward.
    assign chain[ENTRIES] = ~hit;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            logic              pv;
            logic [TAG_W-1:0]  pt;
            logic [SLOT_W-1:0] ps;

            if (g == 0)
            begin : g_head
                assign pv = 1'b1;
                assign pt = key_reg;
                assign ps = new_slot;
            end
            else
            begin : g_body
                assign pv = valid_vec[g-1];
                assign pt = tag_arr[g-1];
                assign ps = slot_arr[g-1];
            end

            lbcd_cell #(
                .SLOT_W (SLOT_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .key        (key_reg),
                .prev_valid (pv),
                .prev_tag   (pt),
                .prev_slot  (ps),
                .shift_in   (chain[g+1]),
                .shift_out  (chain[g]),
                .valid      (valid_vec[g]),
                .tag        (tag_arr[g]),
                .slot       (slot_arr[g]),
                .match      (match_vec[g])
            );
        end
    endgenerate

    // Build the result.
    assign slot_wide = {{OUT_SLOT_W{1'b0}}, new_slot};

    always_comb
    begin
        out_next.hit           = hit;
        out_next.slot          = slot_wide[OUT_SLOT_W-1:0];
        out_next.evicted       = ~hit & full;
        out_next.evicted_block = (~hit & full) ? tag_arr[ENTRIES-1] : '0;
        case (cmd_reg)
            CMD_PUT: out_next.backing_action = hit ? ACT_WRITE_DIFF : ACT_WRITE;
            default: out_next.backing_action = hit ? ACT_NONE : ACT_FETCH;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  state_next = accept ? ST_MATCH : ST_IDLE;
            ST_MATCH: state_next = ST_APPLY;
            ST_APPLY:
            begin
                if (fire)
                begin
                    state_next = accept ? ST_MATCH : ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    assign count_next = (fire && !hit && !full) ? count_reg + CNT_W'(1) : count_reg;
    assign out_valid_next = fire ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    // Hold control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request and the result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= req.data.block_number;
            cmd_reg <= req.data.command;
        end
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // Checks.
    `LBCD_ASSERT_IMP(a_single_hit, clk, rst_n, state_reg == ST_APPLY, $onehot0(match_vec),
        "more than one cell matched the key")
    `LBCD_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(ENTRIES),
        "entry count beyond capacity")
    `LBCD_ASSERT_NEXT(a_miss_grows, clk, rst_n, fire && !hit && !full,
        count_reg == $past(count_reg) + CNT_W'(1), "miss did not take a free slot")
    `LBCD_ASSERT_IMP(a_evict_full, clk, rst_n, fire && !hit && !full,
        !valid_vec[ENTRIES-1], "tail occupied while directory not full")

endmodule

// ===== tb/sv/lru_block_cache_directory_tb.sv =====
`timescale 1ns / 1ps
module lru_block_cache_directory_tb;
    import lbcd_pkg::*;

    localparam int ENTRIES    = DEFAULT_ENTRIES;
    localparam int HOT_BLOCKS = 80;
    localparam int RANDOM_REQ = 1200;
    localparam int TAIL_ITEMS = 150;
    localparam int LONG_HOLD  = 200;
    localparam int HOLD_AFTER = 300;

    logic clk;
    logic rst_n;

    lbcd_req_if req_bus ();
    lbcd_rsp_if rsp_bus ();

    lru_block_cache_directory #(
        .ENTRIES (ENTRIES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus.sink),
        .rsp   (rsp_bus.source)
    );

    // Directory mirror: tags per slot, recency list (front = most recent)
    logic [TAG_W-1:0] tag_of_slot [ENTRIES];
    int               recency_slots [ENTRIES];
    int               occupied_slots;

    req_t pending_requests [$];
    rsp_t awaited_responses [$];

    int total_items;
    int results_seen;
    int mismatches;
    int send_gap;
    int take_gap;
    int hold_cycles;
    bit hold_done;
    bit send_idles;
    bit take_idles;

    // Look up one block, update the mirror, return the response it implies
    function automatic rsp_t lookup_directory(cmd_t cmd, logic [TAG_W-1:0] block);
        rsp_t res;
        int   slot_idx;
        int   pos;
        bit   found;
        res = '0;
        found = 1'b0;
        slot_idx = 0;
        pos = 0;
        for (int i = 0; i < occupied_slots; i++) begin
            if (!found && tag_of_slot[i] == block) begin
                found = 1'b1;
                slot_idx = i;
            end
        end
        if (found) begin
            for (int i = occupied_slots - 1; i >= 0; i--) begin
                if (recency_slots[i] == slot_idx)
                    pos = i;
            end
            res.hit = 1'b1;
            res.backing_action = (cmd == CMD_PUT) ? ACT_WRITE_DIFF : ACT_NONE;
        end else begin
            if (occupied_slots < ENTRIES) begin
                slot_idx = occupied_slots;
                pos = occupied_slots;
                occupied_slots++;
            end else begin
                // full: reuse the least recently used slot
                slot_idx = recency_slots[ENTRIES-1];
                pos = ENTRIES - 1;
                res.evicted = 1'b1;
                res.evicted_block = tag_of_slot[slot_idx];
            end
            tag_of_slot[slot_idx] = block;
            res.backing_action = (cmd == CMD_PUT) ? ACT_WRITE : ACT_FETCH;
        end
        // move the touched slot to the front
        for (int i = pos; i > 0; i--)
            recency_slots[i] = recency_slots[i-1];
        recency_slots[0] = slot_idx;
        res.slot = slot_idx[OUT_SLOT_W-1:0];
        return res;
    endfunction

    function automatic void queue_request(cmd_t cmd, logic [TAG_W-1:0] block);
        req_t item;
        item.command = cmd;
        item.block_number = block;
        pending_requests.push_back(item);
    endfunction

    task automatic note_mismatch(string field, logic [TAG_W-1:0] want, logic [TAG_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s expected 0x%0h, got 0x%0h", $realtime, field, want, got);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Timeout
    initial
    begin
        #2_000_000;
        $display("FAIL lru_block_cache_directory");
        $finish;
    end

    // Sender: offer queued requests, mirror each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
            send_gap <= 0;
            send_idles <= 1'b1;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
                awaited_responses.push_back(lookup_directory(
                    cmd_t'(req_bus.data.command), req_bus.data.block_number));
            if (!req_bus.valid || req_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    req_bus.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_requests.size() > 0)
                begin
                    req_bus.valid <= 1'b1;
                    req_bus.data <= pending_requests.pop_front();
                    if ($urandom_range(0, 39) == 0)
                        send_idles <= !send_idles;
                    if (send_idles && pending_requests.size() > TAIL_ITEMS
                        && $urandom_range(0, 2) == 0)
                        send_gap <= $urandom_range(1, 7);
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off of the receiver, once, so the block backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycles <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_cycles <= LONG_HOLD;
            hold_done <= 1'b1;
        end
    end

    // Receiver: take results with random stall bursts, none near the end
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            take_gap <= 0;
            take_idles <= 1'b1;
        end
        else
        begin
            if ($urandom_range(0, 79) == 0)
                take_idles <= !take_idles;
            if (hold_cycles > 0)
            begin
                rsp_bus.ready <= 1'b0;
            end
            else if (take_gap > 0)
            begin
                rsp_bus.ready <= 1'b0;
                take_gap <= take_gap - 1;
            end
            else if (take_idles && results_seen < total_items - TAIL_ITEMS
                     && $urandom_range(0, 4) == 0)
            begin
                rsp_bus.ready <= 1'b0;
                take_gap <= $urandom_range(0, 6);
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // Monitor: compare each result with the oldest mirrored response
    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            results_seen <= results_seen + 1;
            if (awaited_responses.size() == 0)
            begin
                note_mismatch("unexpected result, slot", '0, TAG_W'(rsp_bus.data.slot));
            end
            else
            begin
                want = awaited_responses.pop_front();
                if (rsp_bus.data.hit !== want.hit)
                    note_mismatch("hit", TAG_W'(want.hit), TAG_W'(rsp_bus.data.hit));
                if (rsp_bus.data.slot !== want.slot)
                    note_mismatch("slot", TAG_W'(want.slot), TAG_W'(rsp_bus.data.slot));
                if (rsp_bus.data.evicted !== want.evicted)
                    note_mismatch("evicted", TAG_W'(want.evicted),
                                  TAG_W'(rsp_bus.data.evicted));
                if (rsp_bus.data.evicted_block !== want.evicted_block)
                    note_mismatch("evicted_block", want.evicted_block,
                                  rsp_bus.data.evicted_block);
                if (rsp_bus.data.backing_action !== want.backing_action)
                    note_mismatch("backing_action", TAG_W'(want.backing_action),
                                  TAG_W'(rsp_bus.data.backing_action));
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        logic [TAG_W-1:0] hot_set [HOT_BLOCKS];
        logic [TAG_W-1:0] last_block;
        logic [TAG_W-1:0] block;
        int               pick;
        rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.data = '0;
        rsp_bus.ready = 1'b0;
        occupied_slots = 0;
        results_seen = 0;
        mismatches = 0;

        // Directed: empty directory, hits and misses of both commands, extremes
        queue_request(CMD_GET, 32'h0000_0000);
        queue_request(CMD_PUT, 32'h0000_0000);
        queue_request(CMD_GET, 32'h0000_0000);
        queue_request(CMD_PUT, 32'hFFFF_FFFF);
        queue_request(CMD_GET, 32'hFFFF_FFFF);
        queue_request(CMD_GET, 32'h0000_0001);
        queue_request(CMD_PUT, 32'h8000_0000);
        queue_request(CMD_GET, 32'h7FFF_FFFF);
        queue_request(CMD_PUT, 32'h5555_5555);
        queue_request(CMD_GET, 32'hAAAA_AAAA);
        queue_request(CMD_GET, 32'h0000_0000);
        queue_request(CMD_PUT, 32'h0000_0001);
        queue_request(CMD_PUT, 32'hFFFF_FFFF);
        queue_request(CMD_GET, 32'hFFFF_FFFE);

        // Random: a hot set larger than the directory gives hits and evictions
        for (int i = 0; i < HOT_BLOCKS; i++)
            hot_set[i] = $urandom;
        last_block = 32'h0;
        for (int n = 0; n < RANDOM_REQ; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
            begin
                block = hot_set[$urandom_range(0, HOT_BLOCKS - 1)];
            end
            else if (pick < 84)
            begin
                block = $urandom;
                hot_set[$urandom_range(0, HOT_BLOCKS - 1)] = block;
            end
            else if (pick < 92)
            begin
                block = last_block;
            end
            else if (pick < 96)
            begin
                block = last_block ^ (32'h1 << $urandom_range(0, 31));
            end
            else
            begin
                block = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
            end
            queue_request(cmd_t'($urandom_range(0, 1)), block);
            last_block = block;
        end
        total_items = pending_requests.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all requests taken, all results seen, then settle
        while (pending_requests.size() > 0 || req_bus.valid
               || awaited_responses.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("PASS lru_block_cache_directory");
        else
            $display("FAIL lru_block_cache_directory");
        $finish;
    end

endmodule
